>>> sv/hbpsr_pkg.sv
package hbpsr_pkg;

    localparam int TSPEED_W = 8;
    localparam int DIR_W    = 2;
    localparam int STEP_W   = 16;

    localparam int SPEED_BITS_DEFAULT    = 8;
    localparam int PRESCALE_BITS_DEFAULT = 16;

    localparam logic [STEP_W-1:0] STEP_TICKS_RESET = 16'd1000;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BWD  = 2'd2;

    typedef struct packed {
        logic [TSPEED_W-1:0] target_speed;
        logic [DIR_W-1:0]    target_direction;
    } req_t;

    typedef struct packed {
        logic                in1_level;
        logic                in2_level;
        logic [TSPEED_W-1:0] present_speed;
        logic [DIR_W-1:0]    present_direction;
        logic                settled;
    } rsp_t;

endpackage

>>> sv/hbridge_pwm_speed_ramp.sv
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// request   | in_valid / in_ready    | target_speed, target_direction
// result    | out_valid / out_ready  | in1_level, in2_level, present_speed,
//           |                        | present_direction, settled
// config    | cfg_write              | cfg_data (step_ticks)
//
// One request per clock while out_ready is high; each accepted request passes
// through the input register, then through the ramp logic into the result
// register. Reset clears the drive state, the valid flags and sets step_ticks to
// 1000. A stalled result holds the ramp stage; the input register still takes one
// more request, then in_ready drops until the result is taken.
module hbridge_pwm_speed_ramp #(
    parameter int SPEED_BITS    = hbpsr_pkg::SPEED_BITS_DEFAULT,
    parameter int PRESCALE_BITS = hbpsr_pkg::PRESCALE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [hbpsr_pkg::STEP_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hbpsr_pkg::TSPEED_W-1:0]  target_speed,
    input  logic [hbpsr_pkg::DIR_W-1:0]     target_direction,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            in1_level,
    output logic                            in2_level,
    output logic [hbpsr_pkg::TSPEED_W-1:0]  present_speed,
    output logic [hbpsr_pkg::DIR_W-1:0]     present_direction,
    output logic                            settled
);
    import hbpsr_pkg::*;

    logic [STEP_W-1:0] step_ticks_reg;
    req_t              in_req;
    req_t              req;
    logic              req_valid;
    logic              req_take;
    rsp_t              rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_ticks_reg <= STEP_TICKS_RESET;
        else if (cfg_write)
            step_ticks_reg <= cfg_data;
    end

    assign in_req.target_speed     = target_speed;
    assign in_req.target_direction = target_direction;

    hbpsr_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req       (req)
    );

    hbpsr_ramp #(
        .SPEED_BITS    (SPEED_BITS),
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_ramp (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_ticks (step_ticks_reg),
        .req_valid  (req_valid),
        .req_take   (req_take),
        .req        (req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rsp        (rsp)
    );

    assign in1_level         = rsp.in1_level;
    assign in2_level         = rsp.in2_level;
    assign present_speed     = rsp.present_speed;
    assign present_direction = rsp.present_direction;
    assign settled           = rsp.settled;

endmodule

>>> sv/hbpsr_in_reg.sv
module hbpsr_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hbpsr_pkg::req_t     in_req,
    output logic                req_valid,
    input  logic                req_take,
    output hbpsr_pkg::req_t     req
);
    import hbpsr_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign in_ready  = !valid_reg || req_take;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (req_take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // hold the request until the ramp stage takes it
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_req;
    end

endmodule

>>> sv/hbpsr_ramp.sv
module hbpsr_ramp #(
    parameter int SPEED_BITS    = hbpsr_pkg::SPEED_BITS_DEFAULT,
    parameter int PRESCALE_BITS = hbpsr_pkg::PRESCALE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hbpsr_pkg::STEP_W-1:0]  step_ticks,
    input  logic                          req_valid,
    output logic                          req_take,
    input  hbpsr_pkg::req_t               req,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hbpsr_pkg::rsp_t               rsp
);
    import hbpsr_pkg::*;

    localparam int CW = (SPEED_BITS > TSPEED_W) ? SPEED_BITS : TSPEED_W;
    localparam int LW = ((PRESCALE_BITS > STEP_W) ? PRESCALE_BITS : STEP_W) + 1;
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;
    localparam logic [LW-1:0] PRESCALE_SPAN = LW'(1) << PRESCALE_BITS;

    logic [SPEED_BITS-1:0]    phase_reg;
    logic [SPEED_BITS-1:0]    phase_next;
    logic [PRESCALE_BITS-1:0] prescale_reg;
    logic [PRESCALE_BITS-1:0] prescale_next;
    logic [SPEED_BITS-1:0]    speed_reg;
    logic [SPEED_BITS-1:0]    speed_next;
    logic [DIR_W-1:0]         dir_reg;
    logic [DIR_W-1:0]         dir_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    logic [CW-1:0]         tsp_wide;
    logic [SPEED_BITS-1:0] tspeed;
    logic [DIR_W-1:0]      tdir;
    logic [LW-1:0]         limit;
    logic [LW-1:0]         count_inc;
    logic                  step;
    logic                  pwm_on;

    assign req_take  = req_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        tsp_wide = CW'(req.target_speed);
        if (tsp_wide > CW'(SPEED_MAX))
            tspeed = SPEED_MAX;
        else
            tspeed = tsp_wide[SPEED_BITS-1:0];
        tdir = req.target_direction;
        if (tdir != DIR_FWD && tdir != DIR_BWD)
            tdir = DIR_NONE;
        if (tdir == DIR_NONE)
            tspeed = '0;

        limit = (step_ticks == '0) ? LW'(1) : LW'(step_ticks);
        if (limit > PRESCALE_SPAN)
            limit = PRESCALE_SPAN;
        count_inc = LW'(prescale_reg) + LW'(1);
        step = (count_inc >= limit);
    end

    always_comb
    begin
        speed_next    = speed_reg;
        dir_next      = dir_reg;
        prescale_next = step ? '0 : count_inc[PRESCALE_BITS-1:0];
        if (step)
        begin
            if (dir_reg == DIR_NONE)
            begin
                if (tspeed != '0)
                begin
                    dir_next   = tdir;
                    speed_next = SPEED_BITS'(1);
                end
            end
            else if (dir_reg == tdir)
            begin
                if (speed_reg < tspeed)
                    speed_next = speed_reg + SPEED_BITS'(1);
                else if (speed_reg > tspeed)
                    speed_next = speed_reg - SPEED_BITS'(1);
            end
            else if (speed_reg != '0)
            begin
                speed_next = speed_reg - SPEED_BITS'(1);
            end
            if (speed_next == '0)
                dir_next = DIR_NONE;
        end
        phase_next = phase_reg + SPEED_BITS'(1);
    end

    always_comb
    begin
        pwm_on = (speed_next == SPEED_MAX) || (phase_reg < speed_next);
        rsp_next.in1_level         = (dir_next == DIR_BWD) && pwm_on;
        rsp_next.in2_level         = (dir_next == DIR_FWD) && pwm_on;
        rsp_next.present_speed     = TSPEED_W'(speed_next);
        rsp_next.present_direction = dir_next;
        rsp_next.settled           = (speed_next == tspeed) &&
                                     ((speed_next == '0) || (dir_next == tdir));
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (req_take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            prescale_reg  <= '0;
            speed_reg     <= '0;
            dir_reg       <= DIR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            // advance the drive state once per request
            if (req_take)
            begin
                phase_reg    <= phase_next;
                prescale_reg <= prescale_next;
                speed_reg    <= speed_next;
                dir_reg      <= dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            rsp_reg <= rsp_next;
    end

endmodule
